// ===== rtl/core/imusfd_pkg.sv =====
// Shared constants, types and helper functions for the serial frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package imusfd_pkg;

	localparam int BUFFER_BYTES = 100;
	localparam int IDX_W        = 7;

	localparam logic [IDX_W-1:0] BUF_LAST  = IDX_W'(BUFFER_BYTES - 1);
	localparam logic [IDX_W-1:0] PAY_FIRST = IDX_W'(4);
	localparam logic [IDX_W-1:0] PAY_END   = IDX_W'(12);
	localparam logic [IDX_W-1:0] POS_TYPE  = IDX_W'(1);

	// payload bytes spread over four lanes, two frame types per lane
	localparam int PAY_LANES  = 4;
	localparam int LANE_DEPTH = 2;
	localparam int LANE_W     = $clog2(PAY_LANES);
	localparam int LANE_AW    = $clog2(LANE_DEPTH);

	localparam logic [7:0] SYNC_FIRST  = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [7:0] TYPE_ATT    = 8'hA1;
	localparam logic [7:0] TYPE_MOT    = 8'hA2;
	localparam logic [7:0] MIN_LEN     = 8'd3;

	localparam logic [1:0] KIND_ATT   = 2'd0;
	localparam logic [1:0] KIND_MOT   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [1:0] REG_PITCH_OFF  = 2'd0;
	localparam logic [1:0] REG_ROLL_OFF   = 2'd1;
	localparam logic [1:0] REG_GPITCH_OFF = 2'd2;
	localparam logic [1:0] REG_GROLL_OFF  = 2'd3;

	typedef struct packed {
		logic               done;
		logic               bad;
		logic [1:0]         kind;
		logic               wr_en;
		logic [LANE_W-1:0]  wr_lane;
		logic [LANE_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
	} frame_evt_t;

	function automatic logic signed [15:0] sign_mag(input logic [7:0] hi, input logic [7:0] lo);
		logic signed [15:0] mag;
		mag = {1'b0, hi[6:0], lo};
		return hi[7] ? -mag : mag;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
		if (x > 18'sd32767) begin
			return 16'sh7fff;
		end else if (x < -18'sd32768) begin
			return 16'sh8000;
		end
		return x[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imusfd_rx_if.sv =====
// Byte request channel into the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface imusfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imusfd_res_if.sv =====
// Frame result channel out of the decoder.
`timescale 1ns / 1ps
`default_nettype none
interface imusfd_res_if;
	logic               valid;
	logic               ready;
	logic               frame_status;
	logic [1:0]         frame_kind;
	logic signed [15:0] pitch_out;
	logic signed [15:0] roll_out;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_y;

	modport source (output valid, output frame_status, output frame_kind, output pitch_out,
		output roll_out, output rate_x, output rate_y, input ready);
	modport sink (input valid, input frame_status, input frame_kind, input pitch_out,
		input roll_out, input rate_x, input rate_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/imusfd_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
`default_nettype none
module imusfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/imusfd_parser.sv =====
// Frame tracker: sync detection, position, length, checksum and payload write steering.
`timescale 1ns / 1ps
`default_nettype none
module imusfd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        rx_byte,
	output      imusfd_pkg::frame_evt_t evt
);
	import imusfd_pkg::*;

	logic [IDX_W-1:0] widx_q;
	logic             hdr_q;
	logic [7:0]       len_q;
	logic [7:0]       type_q;
	logic [7:0]       sum_q;
	logic [7:0]       chk_q;

	logic             restart;
	logic             first;
	logic [7:0]       len_eff;
	logic [8:0]       pos_p2;
	logic [7:0]       pos_p1;
	logic [7:0]       sum_new;
	logic [7:0]       chk_new;
	logic [7:0]       type_new;
	logic [IDX_W-1:0] widx_next;
	logic [IDX_W-1:0] pay_idx;
	logic             in_pay;

	always_comb begin
		restart  = (rx_byte == SYNC_SECOND) && hdr_q;
		first    = (widx_q == '0);
		len_eff  = first ? rx_byte : len_q;
		pos_p2   = {2'b00, widx_q} + 9'd2;
		pos_p1   = {1'b0, widx_q} + 8'd1;
		if (first) begin
			sum_new = rx_byte;
		end else if (pos_p2 < {1'b0, len_eff}) begin
			sum_new = sum_q + rx_byte;
		end else begin
			sum_new = sum_q;
		end
		chk_new  = (pos_p2 == {1'b0, len_eff}) ? rx_byte : chk_q;
		type_new = (widx_q == POS_TYPE) ? rx_byte : type_q;
		// hold at the last slot once the buffer is full
		widx_next = (pos_p1 >= 8'(BUFFER_BYTES)) ? BUF_LAST : pos_p1[IDX_W-1:0];
		in_pay    = (widx_q >= PAY_FIRST) && (widx_q < PAY_END);
		pay_idx   = widx_q - PAY_FIRST;

		evt.done = accept && !restart && (pos_p1 == len_eff);
		evt.bad  = (len_eff < MIN_LEN) || (sum_new != chk_new);
		case (type_new)
			TYPE_ATT: evt.kind = KIND_ATT;
			TYPE_MOT: evt.kind = KIND_MOT;
			default:  evt.kind = KIND_OTHER;
		endcase
		evt.wr_en   = accept && !restart && in_pay;
		evt.wr_lane = pay_idx[LANE_W-1:0];
		evt.wr_addr = pay_idx[LANE_W +: LANE_AW];
		evt.wr_data = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			hdr_q  <= 1'b0;
			len_q  <= '0;
			type_q <= '0;
			sum_q  <= '0;
			chk_q  <= '0;
		end else if (accept) begin
			if (restart) begin
				hdr_q  <= 1'b0;
				widx_q <= '0;
			end else begin
				hdr_q  <= (rx_byte == SYNC_FIRST);
				widx_q <= widx_next;
				len_q  <= len_eff;
				type_q <= type_new;
				sum_q  <= sum_new;
				chk_q  <= chk_new;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/imu_serial_frame_decoder.sv =====
// Top level of the length-prefixed serial frame decoder for attitude sensor data.
//
// Usage:
//   rx  : one received serial byte per request (valid/ready). The pair A5,5A
//         restarts a frame; every other byte is stored at the next position.
//         Byte 0 is the frame length, byte 1 the type, byte length-2 the
//         additive checksum over the bytes before it.
//   res : one request per completed frame: status, kind and the four
//         offset-corrected, saturated values (pitch and pitch rate negated).
//   APB : four 16-bit offset registers at byte addresses 0, 4, 8 and 12.
// Throughput is one byte per cycle while rx.ready is high. A completing byte
// of a good A1 or A2 frame issues one read of the four payload lanes; the
// result goes via the decode slot to the output register. The payload lanes
// are read-first RAMs; the byte written in the completing cycle is forwarded.
// Reset clears the frame tracker, the stored sensor values, the offsets and
// both pipeline slots; payload lanes are not cleared. When the receiver
// stalls, the decode slot and the output register hold two results, then
// rx.ready drops until the output register drains.
`timescale 1ns / 1ps
`default_nettype none
module imu_serial_frame_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	imusfd_rx_if.sink        rx,
	imusfd_res_if.source     res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import imusfd_pkg::*;

	// configuration registers
	logic signed [15:0] pitch_off_q, roll_off_q, gpitch_off_q, groll_off_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_off_q  <= '0;
			roll_off_q   <= '0;
			gpitch_off_q <= '0;
			groll_off_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_PITCH_OFF:  pitch_off_q  <= pwdata[15:0];
				REG_ROLL_OFF:   roll_off_q   <= pwdata[15:0];
				REG_GPITCH_OFF: gpitch_off_q <= pwdata[15:0];
				REG_GROLL_OFF:  groll_off_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PITCH_OFF:  prdata = {16'h0000, pitch_off_q};
			REG_ROLL_OFF:   prdata = {16'h0000, roll_off_q};
			REG_GPITCH_OFF: prdata = {16'h0000, gpitch_off_q};
			REG_GROLL_OFF:  prdata = {16'h0000, groll_off_q};
			default:        prdata = '0;
		endcase
	end

	// handshake and pipeline control
	logic in_acc;
	logic s1_valid_q;
	logic s1_adv;
	logic out_valid_q;

	assign s1_adv   = !out_valid_q || res.ready;
	assign rx.ready = !s1_valid_q || s1_adv;
	assign in_acc   = rx.valid && rx.ready;

	// frame tracker
	frame_evt_t evt;

	imusfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.rx_byte (rx.rx_byte),
		.evt     (evt)
	);

	// payload lanes: lane k holds payload byte k (type A1) and k+4 (type A2)
	logic                rd_en;
	logic [LANE_AW-1:0]  rd_addr;
	logic [7:0]          lane_rdata [PAY_LANES];

	assign rd_en   = evt.done && !evt.bad && (evt.kind != KIND_OTHER);
	assign rd_addr = LANE_AW'(evt.kind == KIND_MOT);

	for (genvar k = 0; k < PAY_LANES; k++) begin : g_lane
		imusfd_ram #(
			.WIDTH (8),
			.DEPTH (LANE_DEPTH)
		) u_lane (
			.clk   (clk),
			.we    (evt.wr_en && (evt.wr_lane == LANE_W'(k))),
			.waddr (evt.wr_addr),
			.wdata (evt.wr_data),
			.re    (rd_en),
			.raddr (rd_addr),
			.rdata (lane_rdata[k])
		);
	end

	// decode slot: status, kind and forwarding of the byte written with the read
	logic                 s1_bad_s1;
	logic [1:0]           s1_kind_s1;
	logic [PAY_LANES-1:0] fwd_s1;
	logic [7:0]           fwd_byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc && evt.done) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && evt.done) begin
			s1_bad_s1   <= evt.bad;
			s1_kind_s1  <= evt.kind;
			fwd_byte_s1 <= evt.wr_data;
			for (int k = 0; k < PAY_LANES; k++) begin
				fwd_s1[k] <= evt.wr_en && (evt.wr_lane == LANE_W'(k))
					&& (evt.wr_addr == rd_addr);
			end
		end
	end

	// sensor values of the last valid frames
	logic signed [15:0] pitch_q, roll_q, groll_q, gpitch_q;
	logic [7:0]         pay [PAY_LANES];
	logic signed [15:0] val_a, val_b;
	logic signed [15:0] pitch_n, roll_n, groll_n, gpitch_n;
	logic               s1_ok;

	always_comb begin
		for (int k = 0; k < PAY_LANES; k++) begin
			pay[k] = fwd_s1[k] ? fwd_byte_s1 : lane_rdata[k];
		end
		val_a = sign_mag(pay[0], pay[1]);
		val_b = sign_mag(pay[2], pay[3]);
		s1_ok = s1_valid_q && !s1_bad_s1;
		pitch_n  = (s1_ok && s1_kind_s1 == KIND_ATT) ? val_a : pitch_q;
		roll_n   = (s1_ok && s1_kind_s1 == KIND_ATT) ? val_b : roll_q;
		groll_n  = (s1_ok && s1_kind_s1 == KIND_MOT) ? val_a : groll_q;
		gpitch_n = (s1_ok && s1_kind_s1 == KIND_MOT) ? val_b : gpitch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= '0;
			roll_q   <= '0;
			groll_q  <= '0;
			gpitch_q <= '0;
		end else if (s1_adv && s1_ok) begin
			pitch_q  <= pitch_n;
			roll_q   <= roll_n;
			groll_q  <= groll_n;
			gpitch_q <= gpitch_n;
		end
	end

	// offset correction, 18 bits so the difference cannot wrap
	logic signed [17:0] d_pitch, d_roll, d_rx, d_ry;

	always_comb begin
		d_pitch = {{2{pitch_off_q[15]}}, pitch_off_q} - {{2{pitch_n[15]}}, pitch_n};
		d_roll  = {{2{roll_n[15]}}, roll_n} - {{2{roll_off_q[15]}}, roll_off_q};
		d_rx    = {{2{gpitch_off_q[15]}}, gpitch_off_q} - {{2{gpitch_n[15]}}, gpitch_n};
		d_ry    = {{2{groll_n[15]}}, groll_n} - {{2{groll_off_q[15]}}, groll_off_q};
	end

	// output register
	logic               o_status_q;
	logic [1:0]         o_kind_q;
	logic signed [15:0] o_pitch_q, o_roll_q, o_rx_q, o_ry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			if (s1_bad_s1) begin
				// checksum mismatch or short length: report zeros
				o_status_q <= STATUS_BAD;
				o_kind_q   <= KIND_ATT;
				o_pitch_q  <= '0;
				o_roll_q   <= '0;
				o_rx_q     <= '0;
				o_ry_q     <= '0;
			end else begin
				o_status_q <= STATUS_OK;
				o_kind_q   <= s1_kind_s1;
				o_pitch_q  <= sat16(d_pitch);
				o_roll_q   <= sat16(d_roll);
				o_rx_q     <= sat16(d_rx);
				o_ry_q     <= sat16(d_ry);
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.frame_status = o_status_q;
	assign res.frame_kind   = o_kind_q;
	assign res.pitch_out    = o_pitch_q;
	assign res.roll_out     = o_roll_q;
	assign res.rate_x       = o_rx_q;
	assign res.rate_y       = o_ry_q;
endmodule
`default_nettype wire
